// ----- src/crp_pkg.sv -----
package crp_pkg;

    // default number of token bytes this endpoint can compare
    localparam int TOKEN_BYTES_DEFAULT = 8;

    localparam int TOKEN_W   = 64;
    localparam int TOKLEN_W  = 4;
    localparam int MID_W     = 16;
    localparam int POS_W     = 16;
    localparam int SKIP_W    = 17;
    localparam int CODE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_TOKEN_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_TOKEN           = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MESSAGE_ID = 2'd2;

    // verdict codes; ST_NONE only lives inside the parser
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ACK      = 3'd1,
        ST_RST      = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_PROTO    = 3'd4,
        ST_NOT_OURS = 3'd5,
        ST_INVALID  = 3'd6,
        ST_NONE     = 3'd7
    } status_t;

    typedef struct packed {
        logic [TOKLEN_W-1:0] own_token_length;
        logic [TOKEN_W-1:0]  own_token;
        logic [MID_W-1:0]    expected_message_id;
    } cfg_t;

    typedef struct packed {
        status_t           status;
        logic [POS_W-1:0]  payload_offset;
        logic [POS_W-1:0]  payload_length;
        logic [CODE_W-1:0] stored_code;
    } result_t;

endpackage

// ----- src/crp_parser.sv -----
module crp_parser
    import crp_pkg::*;
#(
    parameter int TOKEN_BYTES = TOKEN_BYTES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output result_t    result
);

    typedef enum logic [3:0] {
        PH_H0,
        PH_H1,
        PH_H2,
        PH_H3,
        PH_TOKEN,
        PH_OPT,
        PH_DELTA_EXT,
        PH_LEN_EXT1,
        PH_LEN_EXT2,
        PH_VALUE,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic [15:0]         ext_reg, ext_next;
    logic [1:0]          mtype_reg, mtype_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [MID_W-1:0]    mid_reg, mid_next;
    logic [TOKLEN_W-1:0] tkl_reg, tkl_next;
    status_t             verdict_reg, verdict_next;
    logic [POS_W-1:0]    marker_reg, marker_next;
    logic [CODE_W-1:0]   rcode_reg, rcode_next;

    logic [POS_W-1:0]    count;
    logic [POS_W-1:0]    tok_idx;
    logic [2:0]          tok_sel;
    logic [7:0]          tok_want;
    logic                len_nib_en;
    logic [3:0]          len_nib;
    logic                bv_en;
    logic [SKIP_W-1:0]   bv_val;
    logic [SKIP_W-1:0]   skip_dec;

    assign count    = (pos_reg == '1) ? pos_reg : pos_reg + POS_W'(1);
    assign tok_idx  = pos_reg - POS_W'(4);
    assign tok_sel  = 3'd7 - tok_idx[2:0];
    assign tok_want = cfg.own_token[{tok_sel, 3'b000} +: 8];
    assign skip_dec = (skip_reg != '0) ? skip_reg - SKIP_W'(1) : skip_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        ext_next     = ext_reg;
        mtype_next   = mtype_reg;
        code_next    = code_reg;
        mid_next     = mid_reg;
        tkl_next     = tkl_reg;
        verdict_next = verdict_reg;
        marker_next  = marker_reg;
        rcode_next   = rcode_reg;
        len_nib_en   = 1'b0;
        len_nib      = 4'h0;
        bv_en        = 1'b0;
        bv_val       = '0;

        unique case (phase_reg)
            PH_H0:
            begin
                mtype_next = data_byte[5:4];
                tkl_next   = data_byte[3:0];
                if (data_byte[7:6] != 2'b01)
                begin
                    verdict_next = ST_PROTO;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    phase_next = PH_H1;
                end
            end
            PH_H1:
            begin
                code_next  = data_byte;
                phase_next = PH_H2;
            end
            PH_H2:
            begin
                mid_next   = {data_byte, 8'h00};
                phase_next = PH_H3;
            end
            PH_H3:
            begin
                mid_next = {mid_reg[15:8], data_byte};
                if (mtype_reg[1])
                begin
                    // ack or reset: must match our request and carry the empty code
                    phase_next = PH_DONE;
                    if (mid_next == cfg.expected_message_id && code_reg == '0)
                    begin
                        if (mtype_reg == 2'b10)
                        begin
                            rcode_next   = code_reg;
                            verdict_next = ST_ACK;
                        end
                        else
                        begin
                            verdict_next = ST_RST;
                        end
                    end
                    else
                    begin
                        verdict_next = ST_NOT_OURS;
                    end
                end
                else if (mtype_reg == 2'b01)
                begin
                    skip_next = SKIP_W'(tkl_reg);
                    if (tkl_reg != cfg.own_token_length
                        || cfg.own_token_length > TOKLEN_W'(TOKEN_BYTES))
                    begin
                        verdict_next = ST_NOT_OURS;
                    end
                    if (tkl_reg == '0)
                    begin
                        phase_next = (verdict_next != ST_NONE) ? PH_DONE : PH_OPT;
                    end
                    else
                    begin
                        phase_next = PH_TOKEN;
                    end
                end
                else
                begin
                    verdict_next = ST_INVALID;
                    phase_next   = PH_DONE;
                end
            end
            PH_TOKEN:
            begin
                if (verdict_reg == ST_NONE)
                begin
                    if (tok_idx < POS_W'(TOKEN_BYTES) && tok_idx < POS_W'(8))
                    begin
                        if (tok_want != data_byte)
                        begin
                            verdict_next = ST_NOT_OURS;
                        end
                    end
                    else
                    begin
                        verdict_next = ST_NOT_OURS;
                    end
                end
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = (verdict_next != ST_NONE) ? PH_DONE : PH_OPT;
                end
            end
            PH_OPT:
            begin
                if (data_byte == 8'hFF)
                begin
                    marker_next = count;
                    phase_next  = PH_PAYLOAD;
                end
                else if (data_byte[7:4] == 4'hF)
                begin
                    verdict_next = ST_PROTO;
                    phase_next   = PH_DONE;
                end
                else if (data_byte[7:4] == 4'hD || data_byte[7:4] == 4'hE)
                begin
                    skip_next  = (data_byte[7:4] == 4'hD) ? SKIP_W'(1) : SKIP_W'(2);
                    ext_next   = {12'h000, data_byte[3:0]};
                    phase_next = PH_DELTA_EXT;
                end
                else
                begin
                    len_nib_en = 1'b1;
                    len_nib    = data_byte[3:0];
                end
            end
            PH_DELTA_EXT:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    len_nib_en = 1'b1;
                    len_nib    = ext_reg[3:0];
                end
            end
            PH_LEN_EXT1:
            begin
                if (ext_reg == 16'h000D)
                begin
                    bv_en  = 1'b1;
                    bv_val = SKIP_W'(data_byte) + SKIP_W'(13);
                end
                else
                begin
                    ext_next   = {8'h00, data_byte};
                    phase_next = PH_LEN_EXT2;
                end
            end
            PH_LEN_EXT2:
            begin
                bv_en  = 1'b1;
                bv_val = {1'b0, ext_reg[7:0], data_byte} + SKIP_W'(269);
            end
            PH_VALUE:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_OPT;
                end
            end
            PH_PAYLOAD:
            begin
                phase_next = PH_PAYLOAD;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // option length nibble, shared by plain and delta-extended headers
        if (len_nib_en)
        begin
            if (len_nib == 4'hF)
            begin
                verdict_next = ST_PROTO;
                phase_next   = PH_DONE;
            end
            else if (len_nib == 4'hD || len_nib == 4'hE)
            begin
                ext_next   = {12'h000, len_nib};
                phase_next = PH_LEN_EXT1;
            end
            else
            begin
                bv_en  = 1'b1;
                bv_val = SKIP_W'(len_nib);
            end
        end

        // start of an option value
        if (bv_en)
        begin
            skip_next  = bv_val;
            phase_next = (bv_val != '0) ? PH_VALUE : PH_OPT;
        end

        // verdict for the datagram, from the state after this byte
        result.payload_offset = '0;
        result.payload_length = '0;
        if (count < POS_W'(4) || phase_next == PH_TOKEN)
        begin
            result.status = ST_OVERFLOW;
        end
        else if (verdict_next != ST_NONE)
        begin
            result.status = verdict_next;
        end
        else if (phase_next == PH_OPT)
        begin
            result.status         = ST_OK;
            result.payload_offset = count;
        end
        else if (phase_next == PH_PAYLOAD && count > marker_next)
        begin
            result.status         = ST_OK;
            result.payload_offset = marker_next;
            result.payload_length = count - marker_next;
        end
        else
        begin
            result.status = ST_OVERFLOW;
        end

        if (last_byte && result.status == ST_OK)
        begin
            rcode_next = code_next;
        end
        result.stored_code = rcode_next;

        pos_next = count;

        // back to the header for the next datagram
        if (last_byte)
        begin
            phase_next   = PH_H0;
            pos_next     = '0;
            skip_next    = '0;
            ext_next     = '0;
            mtype_next   = '0;
            code_next    = '0;
            mid_next     = '0;
            tkl_next     = '0;
            verdict_next = ST_NONE;
            marker_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_H0;
            pos_reg     <= '0;
            skip_reg    <= '0;
            ext_reg     <= '0;
            mtype_reg   <= '0;
            code_reg    <= '0;
            mid_reg     <= '0;
            tkl_reg     <= '0;
            verdict_reg <= ST_NONE;
            marker_reg  <= '0;
            rcode_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            ext_reg     <= ext_next;
            mtype_reg   <= mtype_next;
            code_reg    <= code_next;
            mid_reg     <= mid_next;
            tkl_reg     <= tkl_next;
            verdict_reg <= verdict_next;
            marker_reg  <= marker_next;
            rcode_reg   <= rcode_next;
        end
    end

endmodule

// ----- src/coap_response_parser.sv -----
// the verdict of a datagram is registered and is on the outputs in the cycle after its last beat
// throughput: one byte beat per cycle while in_ready is high, set by the single-pass parser step
// input stalls only while a verdict waits in the output register and out_ready is low
// reset: asynchronous, clears configuration, parser state and the stored response code
// no memory, so no clearing pass after reset
module coap_response_parser
    import crp_pkg::*;
#(
    parameter int TOKEN_BYTES = TOKEN_BYTES_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TOKEN_W-1:0]   cfg_data,

    // datagram byte beats
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,

    // one verdict beat per datagram
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic [POS_W-1:0]     payload_offset,
    output logic [POS_W-1:0]     payload_length,
    output logic [CODE_W-1:0]    stored_code
);

    cfg_t    cfg_reg;
    result_t step_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    in_fire;
    logic    cfg_fire;

    // config writes are always taken; writes beyond the register list are dropped
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // the output register parts the two sides: a byte is taken while the
    // pending verdict leaves in the same cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_OWN_TOKEN_LENGTH:
                begin
                    cfg_reg.own_token_length <= cfg_data[TOKLEN_W-1:0];
                end
                CFG_OWN_TOKEN:
                begin
                    cfg_reg.own_token <= cfg_data;
                end
                CFG_EXPECTED_MESSAGE_ID:
                begin
                    cfg_reg.expected_message_id <= cfg_data[MID_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // per-byte header, token and option walk
    crp_parser #(
        .TOKEN_BYTES (TOKEN_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (in_fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .result    (step_result)
    );

    // verdict register, loaded on the last byte of a datagram
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last_byte)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = 3'(out_reg.status);
    assign payload_offset = out_reg.payload_offset;
    assign payload_length = out_reg.payload_length;
    assign stored_code    = out_reg.stored_code;

    // a last byte always produces a verdict beat in the next cycle
    a_last_gives_verdict: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_fire && last_byte) |=> out_valid
    ) else $error("last byte did not produce a verdict");

    // the internal no-verdict code never reaches the port
    a_no_none_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_reg.status != ST_NONE)
    ) else $error("verdict without a decided status");

    // error verdicts carry zero offset and length
    a_error_zero_payload: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_reg.status != ST_OK) |->
            (payload_offset == '0 && payload_length == '0)
    ) else $error("error verdict with payload fields");

    // an ok verdict points past the four header bytes
    a_ok_offset: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_reg.status == ST_OK) |-> (payload_offset >= POS_W'(4))
    ) else $error("ok verdict with offset inside the header");

endmodule
